[hw/rtl/cro_pkg.sv]
// ----------------------------------------------------------------------------
// cro_pkg: shared types and microcode for the circle rasterizer
// Holds the control word format, the step sequence ROM and the coverage
// mode masks used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cro_pkg;

	// Command codes on func.
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// Coverage modes.
	localparam logic [2:0] MODE_FULL        = 3'd0;
	localparam logic [2:0] MODE_UPPER       = 3'd1;
	localparam logic [2:0] MODE_LOWER       = 3'd2;
	localparam logic [2:0] MODE_UPPER_LEFT  = 3'd3;
	localparam logic [2:0] MODE_UPPER_RIGHT = 3'd4;
	localparam logic [2:0] MODE_LOWER_LEFT  = 3'd5;
	localparam logic [2:0] MODE_LOWER_RIGHT = 3'd6;

	// Step counter width and the addresses the program uses.
	localparam int PC_BITS = 4;
	localparam logic [PC_BITS-1:0] PC_IDLE  = 4'd0;
	localparam logic [PC_BITS-1:0] PC_SLOT0 = 4'd1;
	localparam logic [PC_BITS-1:0] PC_SLOT7 = 4'd8;

	// Jump kinds of a control word.
	localparam logic JMP_NEXT = 1'b0;  // fall through to the next word
	localparam logic JMP_GO   = 1'b1;  // go to target on a start or an active step, else idle

	// One microcode word.
	typedef struct packed {
		logic               ready;   // a command transfer may be taken here
		logic               emit;    // present one symmetric pixel slot
		logic [2:0]         slot;    // bit 0 mirror column, bit 1 mirror row, bit 2 swap
		logic               jump;
		logic [PC_BITS-1:0] target;
	} uword_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic       load;     // take a new circle
		logic       advance;  // advance one step of the circle
		logic       emit;
		logic [2:0] slot;
	} ctrl_t;

	// The program: wait, then walk the eight symmetric slots. The last slot
	// word also takes the next command so items follow without a gap.
	function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
		uword_t w;
		w = '{ready: 1'b0, emit: 1'b0, slot: 3'd0, jump: JMP_GO, target: PC_IDLE};
		case (pc)
			PC_IDLE:  w = '{ready: 1'b1, emit: 1'b0, slot: 3'd0, jump: JMP_GO, target: PC_SLOT0};
			PC_SLOT0: w = '{ready: 1'b0, emit: 1'b1, slot: 3'd0, jump: JMP_NEXT, target: PC_IDLE};
			4'd2: w = '{ready: 1'b0, emit: 1'b1, slot: 3'd1, jump: JMP_NEXT, target: PC_IDLE};
			4'd3: w = '{ready: 1'b0, emit: 1'b1, slot: 3'd2, jump: JMP_NEXT, target: PC_IDLE};
			4'd4: w = '{ready: 1'b0, emit: 1'b1, slot: 3'd3, jump: JMP_NEXT, target: PC_IDLE};
			4'd5: w = '{ready: 1'b0, emit: 1'b1, slot: 3'd4, jump: JMP_NEXT, target: PC_IDLE};
			4'd6: w = '{ready: 1'b0, emit: 1'b1, slot: 3'd5, jump: JMP_NEXT, target: PC_IDLE};
			4'd7: w = '{ready: 1'b0, emit: 1'b1, slot: 3'd6, jump: JMP_NEXT, target: PC_IDLE};
			PC_SLOT7: w = '{ready: 1'b1, emit: 1'b1, slot: 3'd7, jump: JMP_GO, target: PC_SLOT0};
			default: w = '{ready: 1'b0, emit: 1'b0, slot: 3'd0, jump: JMP_GO, target: PC_IDLE};
		endcase
		return w;
	endfunction

	// Which of the eight symmetric pixels each coverage mode keeps.
	function automatic logic [7:0] mode_mask(input logic [2:0] mode);
		logic [7:0] m;
		m = 8'h00;
		case (mode)
			MODE_FULL:        m = 8'hFF;
			MODE_UPPER:       m = 8'h33;
			MODE_LOWER:       m = 8'hCC;
			MODE_UPPER_LEFT:  m = 8'h22;
			MODE_UPPER_RIGHT: m = 8'h11;
			MODE_LOWER_LEFT:  m = 8'h88;
			MODE_LOWER_RIGHT: m = 8'h44;
			default:          m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

[hw/rtl/cro_useq.sv]
// ----------------------------------------------------------------------------
// cro_useq: microcoded step sequencer
// Runs the control program from the package ROM with a step counter and
// conditional jumps, and decodes command transfers into datapath controls.
// ----------------------------------------------------------------------------
module cro_useq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          func,
	input  logic          running,
	output logic          busy,
	output cro_pkg::ctrl_t ctrl
);
	import cro_pkg::*;

	logic [PC_BITS-1:0] pc_q;
	logic [PC_BITS-1:0] pc_next;
	uword_t             word;
	logic               take;
	logic               go;

	// Fetch the current control word.
	assign word = ucode(pc_q);
	assign busy = !word.ready;

	// A step with no circle active is taken but does nothing.
	assign take = start && word.ready;
	assign go   = take && ((func == FUNC_START) || running);

	// Datapath controls for this cycle.
	always_comb begin
		ctrl.load    = go && (func == FUNC_START);
		ctrl.advance = go && (func == FUNC_STEP);
		ctrl.emit    = word.emit;
		ctrl.slot    = word.slot;
	end

	// Next step address.
	always_comb begin
		case (word.jump)
			JMP_NEXT: pc_next = PC_BITS'(pc_q + 1'b1);
			JMP_GO:   pc_next = go ? word.target : PC_IDLE;
			default:  pc_next = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

[hw/rtl/cro_datapath.sv]
// ----------------------------------------------------------------------------
// cro_datapath: circle state, decision update and pixel output
// Holds center, step position, decision term and mode; computes one
// midpoint step and the mirrored pixel of the selected slot.
// ----------------------------------------------------------------------------
module cro_datapath #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cro_pkg::ctrl_t               ctrl,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-2:0]        radius,
	input  logic [2:0]                   cover_mode,
	output logic                         running,
	output logic                         pixel_strobe,
	output logic signed [COORD_BITS+1:0] pixel_x,
	output logic signed [COORD_BITS+1:0] pixel_y,
	output logic                         last_of_run,
	output logic                         circle_done
);
	import cro_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int YW = COORD_BITS + 1;  // signed step_y
	localparam int DW = COORD_BITS + 4;  // signed decision term
	localparam int PW = COORD_BITS + 2;  // pixel coordinate

	logic [CB-1:0] cx_q;
	logic [CB-1:0] cy_q;
	logic [CB-1:0] sx_q;
	logic [YW-1:0] sy_q;
	logic [DW-1:0] dec_q;
	logic [2:0]    mode_q;
	logic          running_q;
	logic          finish_q;

	logic [CB-1:0] x_n;
	logic [YW-1:0] y_n;
	logic [DW-1:0] diff;
	logic [DW-1:0] dec_n;
	logic          dec_pos;
	logic          fin_n;

	logic [PW-1:0] cxw;
	logic [PW-1:0] cyw;
	logic [PW-1:0] xw;
	logic [PW-1:0] yw;
	logic [PW-1:0] a;
	logic [PW-1:0] b;
	logic [PW-1:0] px;
	logic [PW-1:0] py;
	logic [7:0]    rest;
	logic          keep;
	logic          last;

	logic          strobe_q;
	logic [PW-1:0] px_q;
	logic [PW-1:0] py_q;
	logic          last_q;
	logic          done_q;

	// One midpoint step: x always advances, y drops when the term is positive.
	always_comb begin
		dec_pos = !dec_q[DW-1] && (dec_q != '0);
		x_n     = CB'(sx_q + 1'b1);
		y_n     = dec_pos ? YW'(sy_q - 1'b1) : sy_q;
		diff    = DW'({{(DW-CB){1'b0}}, x_n} - {{(DW-YW){y_n[YW-1]}}, y_n});
		if (dec_pos) begin
			dec_n = DW'(dec_q + {diff[DW-3:0], 2'b00} + DW'(10));
		end else begin
			dec_n = DW'(dec_q + {{(DW-CB-2){1'b0}}, x_n, 2'b00} + DW'(6));
		end
		fin_n = $signed(y_n) < $signed({1'b0, x_n});
	end

	// Circle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q      <= '0;
			cy_q      <= '0;
			sx_q      <= '0;
			sy_q      <= '0;
			dec_q     <= '0;
			mode_q    <= '0;
			running_q <= 1'b0;
			finish_q  <= 1'b0;
		end else if (ctrl.load) begin
			cx_q      <= center_x;
			cy_q      <= center_y;
			mode_q    <= cover_mode;
			sx_q      <= '0;
			sy_q      <= {2'b00, radius};
			dec_q     <= DW'(DW'(3) - {{(DW-CB){1'b0}}, radius, 1'b0});
			running_q <= 1'b1;
			finish_q  <= 1'b0;
		end else if (ctrl.advance) begin
			sx_q      <= x_n;
			sy_q      <= y_n;
			dec_q     <= dec_n;
			running_q <= !fin_n;
			finish_q  <= fin_n;
		end
	end

	assign running = running_q;

	// Mirrored pixel of the current slot.
	always_comb begin
		cxw  = {2'b00, cx_q};
		cyw  = {2'b00, cy_q};
		xw   = {2'b00, sx_q};
		yw   = {sy_q[YW-1], sy_q};
		a    = ctrl.slot[2] ? yw : xw;
		b    = ctrl.slot[2] ? xw : yw;
		px   = ctrl.slot[0] ? PW'(cxw - a) : PW'(cxw + a);
		py   = ctrl.slot[1] ? PW'(cyw - b) : PW'(cyw + b);
		rest = mode_mask(mode_q) >> ctrl.slot;
		keep = rest[0];
		last = rest[0] && (rest[7:1] == 7'd0);
	end

	// Result register: one transfer per emitted slot that the mode keeps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctrl.emit && keep;
		end
	end

	always_ff @(posedge clk) begin
		px_q   <= px;
		py_q   <= py;
		last_q <= last;
		done_q <= last && finish_q;
	end

	assign pixel_strobe = strobe_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign last_of_run  = last_q;
	assign circle_done  = done_q;

endmodule

[hw/rtl/circle_rasterizer_octant_modes.sv]
// ----------------------------------------------------------------------------
// circle_rasterizer_octant_modes: midpoint circle rasterizer, top level
// Draws the pixels of a circle one step at a time, filtered by a coverage
// mode (full, half or quarter).
// ----------------------------------------------------------------------------
// Usage:
// A command transfer happens at a rising edge with start high and busy low.
// func selects start (load center, radius and mode, emit the first point) or
// step (advance one point and emit its mirrored pixels). A step with no
// circle active is taken and produces nothing.
// Pixels leave on pixel_x and pixel_y, each valid for exactly one cycle with
// pixel_strobe high; last_of_run marks the last pixel of a command and
// circle_done the last pixel of the whole circle. The receiver cannot stall.
// Timing: the sequencer walks eight symmetric slots, one per cycle, for each
// start or active step, and holds busy up to the last slot word, which takes
// the next command. Slots appear in order, each pixel through the result
// register; slots not kept by the mode are skipped in the output but still
// take their place in the walk. A step while idle does not make the block busy.
// Reset clears the circle state and returns the sequencer to its idle step;
// no pixel is shown until the first start command.
// ----------------------------------------------------------------------------
module circle_rasterizer_octant_modes #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-2:0]        radius,
	input  logic [2:0]                   cover_mode,
	output logic                         pixel_strobe,
	output logic signed [COORD_BITS+1:0] pixel_x,
	output logic signed [COORD_BITS+1:0] pixel_y,
	output logic                         last_of_run,
	output logic                         circle_done
);
	import cro_pkg::*;

	ctrl_t ctrl;
	logic  running;

	// Control program.
	cro_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.running (running),
		.busy    (busy),
		.ctrl    (ctrl)
	);

	// Circle state and pixel generation.
	cro_datapath #(
		.COORD_BITS(COORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.cover_mode   (cover_mode),
		.running      (running),
		.pixel_strobe (pixel_strobe),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_run  (last_of_run),
		.circle_done  (circle_done)
	);

endmodule

[hw/rtl/cro_checker.sv]
// ----------------------------------------------------------------------------
// cro_checker: port level checks for the circle rasterizer
// Watches the command and pixel ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module cro_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic func,
	input logic pixel_strobe,
	input logic last_of_run,
	input logic circle_done
);
	import cro_pkg::*;

	// The end of a circle is always the end of its command's run.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_strobe && circle_done |-> last_of_run)
		else $error("circle_done without last_of_run");

	// A start transfer always opens a run of slots.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_START) |=> busy)
		else $error("start transfer did not make the block busy");

	// The block only turns busy because of a command transfer.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// A run of slots holds busy until its last slot word, then the block is ready again.
	a_busy_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> busy[*7] ##1 !busy)
		else $error("busy did not last exactly seven cycles");

endmodule

bind circle_rasterizer_octant_modes cro_checker u_cro_checker (.*);

[bench/circle_rasterizer_octant_modes_tb.sv]
// ----------------------------------------------------------------------------
// circle_rasterizer_octant_modes_tb: self-checking bench for the rasterizer
// Sends start and step commands over the start/busy handshake and predicts
// every pixel transfer from its own midpoint circle model. A directed table
// covers idle steps, zero and full radius, every coverage mode, mode seven
// and restarts. Random circles of mostly small radius follow, with random
// sender gaps in several phases.
// ----------------------------------------------------------------------------
module circle_rasterizer_octant_modes_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cro_pkg::*;

	localparam int CB           = 12;
	localparam int PB           = CB + 2;
	localparam int NO_CHECK     = -1;
	localparam int N_DIRECTED   = 25;
	localparam int PHASE_ITEMS  = 59;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;

	// Coverage code that keeps no pixel at all.
	localparam logic [2:0] MODE_NONE = 3'd7;

	// One command, with an optional hand-worked count and first pixel.
	typedef struct {
		logic          func;
		logic [CB-1:0] cx;
		logic [CB-1:0] cy;
		logic [CB-2:0] r;
		logic [2:0]    mode;
		int            exp_n;
		int            exp_x;
		int            exp_y;
	} cmd_t;

	// One expected pixel transfer.
	typedef struct {
		logic signed [PB-1:0] px;
		logic signed [PB-1:0] py;
		logic                 run_last;
		logic                 circ_done;
	} pixel_t;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 func       = 1'b0;
	logic [CB-1:0]        center_x   = '0;
	logic [CB-1:0]        center_y   = '0;
	logic [CB-2:0]        radius     = '0;
	logic [2:0]           cover_mode = '0;
	logic                 busy;
	logic                 pixel_strobe;
	logic signed [PB-1:0] pixel_x;
	logic signed [PB-1:0] pixel_y;
	logic                 last_of_run;
	logic                 circle_done;

	// Circle state of the predictor.
	logic [CB-1:0]        circ_cx      = '0;
	logic [CB-1:0]        circ_cy      = '0;
	logic [2:0]           circ_mode    = '0;
	logic [CB-1:0]        circ_x       = '0;
	logic signed [CB:0]   circ_y       = '0;
	logic signed [15:0]   circ_d       = '0;
	logic                 circ_running = 1'b0;

	pixel_t pixel_q[$];
	cmd_t   drive_cmd;
	int     fail_count     = 0;
	int     cmds_taken     = 0;
	int     starts_taken   = 0;
	int     pixels_checked = 0;
	int     circles_closed = 0;
	int     cycle_count    = 0;

	// Directed commands. Fields of step rows are junk that must be ignored.
	cmd_t directed_rows [N_DIRECTED] = '{
		'{FUNC_STEP,  12'hFFF, 12'hFFF, 11'h7FF, MODE_FULL,        0,        0,    0},
		'{FUNC_START, 12'd100, 12'd200, 11'd0,   MODE_FULL,        8,      100,  200},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_NONE,        8,      101,  199},
		'{FUNC_STEP,  12'hABC, 12'h123, 11'h555, MODE_LOWER,       0,        0,    0},
		'{FUNC_START, 12'd4095, 12'd4095, 11'd2047, MODE_FULL,     8,     4095, 6142},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,  NO_CHECK,       0,    0},
		'{FUNC_START, 12'd0,   12'd0,   11'd2047, MODE_UPPER,      4,        0, 2047},
		'{FUNC_STEP,  12'hFFF, 12'h000, 11'h3FF, MODE_NONE,  NO_CHECK,       0,    0},
		'{FUNC_START, 12'd0,   12'd0,   11'd2047, MODE_LOWER,      4,        0, -2047},
		'{FUNC_START, 12'd4095, 12'd0,  11'd2047, MODE_UPPER_LEFT, 2,     4095, 2047},
		'{FUNC_START, 12'd0, 12'd4095,  11'd2047, MODE_UPPER_RIGHT, 2,       0, 6142},
		'{FUNC_START, 12'd2048, 12'd2048, 11'd5,  MODE_LOWER_LEFT, 2,     2048, 2043},
		'{FUNC_START, 12'd1000, 12'd1000, 11'd3,  MODE_LOWER_RIGHT, 2,    1000,  997},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,  NO_CHECK,       0,    0},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,  NO_CHECK,       0,    0},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,  NO_CHECK,       0,    0},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,        0,        0,    0},
		'{FUNC_START, 12'd500, 12'd600, 11'd7,   MODE_NONE,        0,        0,    0},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,        0,        0,    0},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,        0,        0,    0},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,        0,        0,    0},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,        0,        0,    0},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,        0,        0,    0},
		'{FUNC_START, 12'd3000, 12'd2000, 11'd1, MODE_FULL,        8,     3000, 2001},
		'{FUNC_STEP,  12'd0,   12'd0,   11'd0,   MODE_FULL,        8,     3001, 2000}
	};

	circle_rasterizer_octant_modes #(
		.COORD_BITS(CB)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.cover_mode  (cover_mode),
		.pixel_strobe(pixel_strobe),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last_of_run (last_of_run),
		.circle_done (circle_done)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Whether a coverage mode keeps a symmetric slot. Slot bit 1 mirrors the
	// row (cleared means upper half), bit 0 mirrors the column (set means left).
	function automatic bit slot_kept(input logic [2:0] mode, input int s);
		bit upper;
		bit left;
		upper = (s & 2) == 0;
		left  = (s & 1) != 0;
		case (mode)
			MODE_FULL:        return 1'b1;
			MODE_UPPER:       return upper;
			MODE_LOWER:       return !upper;
			MODE_UPPER_LEFT:  return upper && left;
			MODE_UPPER_RIGHT: return upper && !left;
			MODE_LOWER_LEFT:  return !upper && left;
			MODE_LOWER_RIGHT: return !upper && !left;
			default:          return 1'b0;
		endcase
	endfunction

	// Advances the circle for one command and queues the pixels it draws.
	// Returns how many pixels were queued.
	function automatic int trace_command(input cmd_t c);
		pixel_t pts[8];
		int     n;
		int     a;
		int     b;
		bit     finishing;
		n = 0;
		finishing = 1'b0;
		if (c.func == FUNC_START) begin
			circ_cx      = c.cx;
			circ_cy      = c.cy;
			circ_mode    = c.mode;
			circ_x       = '0;
			circ_y       = $signed({2'b00, c.r});
			circ_d       = 16'(3 - 2 * int'(c.r));
			circ_running = 1'b1;
		end else if (!circ_running) begin
			return 0;
		end else begin
			// Midpoint update: y drops only while the decision term is positive.
			circ_x = circ_x + 1'b1;
			if (circ_d > 0) begin
				circ_y = circ_y - 13'sd1;
				circ_d = 16'(int'(circ_d) + 4 * (int'(circ_x) - int'(circ_y)) + 10);
			end else begin
				circ_d = 16'(int'(circ_d) + 4 * int'(circ_x) + 6);
			end
			finishing = int'(circ_y) < int'(circ_x);
			if (finishing)
				circ_running = 1'b0;
		end
		// Bit 2 of a slot swaps x and y before mirroring.
		for (int s = 0; s < 8; s++) begin
			if (slot_kept(circ_mode, s)) begin
				a = (s & 4) ? int'(circ_y) : int'(circ_x);
				b = (s & 4) ? int'(circ_x) : int'(circ_y);
				pts[n].px        = PB'((s & 1) ? int'(circ_cx) - a : int'(circ_cx) + a);
				pts[n].py        = PB'((s & 2) ? int'(circ_cy) - b : int'(circ_cy) + b);
				pts[n].run_last  = 1'b0;
				pts[n].circ_done = 1'b0;
				n++;
			end
		end
		if (n > 0) begin
			pts[n-1].run_last  = 1'b1;
			pts[n-1].circ_done = finishing;
		end
		for (int i = 0; i < n; i++)
			pixel_q.push_back(pts[i]);
		return n;
	endfunction

	function automatic cmd_t random_fields();
		cmd_t c;
		c.func  = 1'($urandom_range(1));
		c.cx    = CB'($urandom);
		c.cy    = CB'($urandom);
		c.r     = (CB-1)'($urandom);
		c.mode  = 3'($urandom);
		c.exp_n = NO_CHECK;
		c.exp_x = 0;
		c.exp_y = 0;
		return c;
	endfunction

	// Holds start high with the command until a transfer, after random gaps.
	task automatic send_cmd(input cmd_t c, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		func       <= c.func;
		center_x   <= c.cx;
		center_y   <= c.cy;
		radius     <= c.r;
		cover_mode <= c.mode;
		drive_cmd  <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Mostly whole circles with random content, some cut short by a restart,
	// and a share of raw random commands.
	task automatic run_phase(input int idle_pct, input int n_items);
		cmd_t c;
		int   sent;
		int   pick;
		int   n_steps;
		sent = 0;
		while (sent < n_items) begin
			c = random_fields();
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_cmd(c, idle_pct);
				sent++;
			end else begin
				c.func = FUNC_START;
				if (pick < 70)
					c.r = (CB-1)'($urandom_range(0, 12));
				else if (pick < 90)
					c.r = (CB-1)'($urandom_range(13, 60));
				c.mode = ($urandom_range(15) == 0) ? MODE_NONE : 3'($urandom_range(0, 6));
				// Enough steps to close a small circle, plus a few idle steps.
				if (c.r <= 60 && $urandom_range(3) != 0)
					n_steps = (int'(c.r) * 3) / 4 + 1 + $urandom_range(0, 2);
				else
					n_steps = $urandom_range(0, 12);
				// Keep the phase within its item budget.
				if (n_steps > n_items - sent - 1)
					n_steps = n_items - sent - 1;
				send_cmd(c, idle_pct);
				sent++;
				repeat (n_steps) begin
					c = random_fields();
					c.func = FUNC_STEP;
					send_cmd(c, idle_pct);
					sent++;
				end
			end
		end
	endtask

	// Command and pixel monitor: predicts on each command transfer and checks
	// each pixel transfer against the oldest expected pixel.
	always @(posedge clk) begin
		cmd_t   seen;
		pixel_t want;
		int     base;
		int     n;
		if (start && !busy) begin
			seen      = drive_cmd;
			seen.func = func;
			seen.cx   = center_x;
			seen.cy   = center_y;
			seen.r    = radius;
			seen.mode = cover_mode;
			base = pixel_q.size();
			n = trace_command(seen);
			cmds_taken++;
			if (seen.func == FUNC_START)
				starts_taken++;
			if (seen.exp_n != NO_CHECK) begin
				if (n != seen.exp_n) begin
					$error("pixel count: expected %0d, got %0d", seen.exp_n, n);
					fail_count++;
				end else if (n > 0 && (int'(pixel_q[base].px) != seen.exp_x ||
						int'(pixel_q[base].py) != seen.exp_y)) begin
					$error("first pixel_x/pixel_y: expected %0d/%0d, got %0d/%0d",
						seen.exp_x, seen.exp_y, pixel_q[base].px, pixel_q[base].py);
					fail_count++;
				end
			end
		end
		if (pixel_strobe) begin
			if (pixel_q.size() == 0) begin
				$error("pixel transfer with nothing expected: pixel_x %0d, pixel_y %0d",
					pixel_x, pixel_y);
				fail_count++;
			end else begin
				want = pixel_q.pop_front();
				pixels_checked++;
				if (want.circ_done)
					circles_closed++;
				if (pixel_x !== want.px) begin
					$error("pixel_x: expected %0d, got %0d", want.px, pixel_x);
					fail_count++;
				end
				if (pixel_y !== want.py) begin
					$error("pixel_y: expected %0d, got %0d", want.py, pixel_y);
					fail_count++;
				end
				if (last_of_run !== want.run_last) begin
					$error("last_of_run: expected %0b, got %0b", want.run_last, last_of_run);
					fail_count++;
				end
				if (circle_done !== want.circ_done) begin
					$error("circle_done: expected %0b, got %0b", want.circ_done, circle_done);
					fail_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding",
				cycle_count, pixel_q.size());
			$display("circle_rasterizer_octant_modes_tb: errors");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			send_cmd(directed_rows[i], 0);
		run_phase(0, PHASE_ITEMS);
		run_phase(66, PHASE_ITEMS);
		run_phase(0, PHASE_ITEMS);
		run_phase(32, PHASE_ITEMS);
		start <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d commands taken (%0d starts), %0d pixels checked, %0d circles closed",
			cmds_taken, starts_taken, pixels_checked, circles_closed);
		$display("sender gaps of 0, 66 and 32 percent, %0d mismatches", fail_count);
		if (fail_count == 0)
			$display("circle_rasterizer_octant_modes_tb: clean");
		else
			$display("circle_rasterizer_octant_modes_tb: errors");
		$finish;
	end

endmodule
